// ===== rtl/epsilon_neighborhood_query_unit_macros.svh =====
// Assertion macros for the checker file of the neighborhood query unit.
`ifndef EPSILON_NEIGHBORHOOD_QUERY_UNIT_MACROS_SVH
`define EPSILON_NEIGHBORHOOD_QUERY_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ENQ_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ENQ_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/enq_pkg.sv =====
// Shared widths, codes and scan pipeline types of the neighborhood query unit.
package enq_pkg;

  localparam int unsigned MAX_POINTS_DEF = 64;
  localparam int unsigned DIMS_DEF       = 4;

  localparam int unsigned COORD_W   = 16;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned DIM_W     = 2;
  localparam int unsigned RADIUS_W  = 35;
  localparam int unsigned COUNT_W   = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned SQ_W      = 2 * COORD_W;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SQ   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = CFG_IDX_W'(1);

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(64);

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_QUERY = 1'b1
  } mode_e;

  // One scanned point entering the distance pipeline.
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [IDX_W-1:0] idx;
  } scan_tag_t;

  // One scanned point leaving the distance pipeline.
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic             last;
    logic [IDX_W-1:0] idx;
  } scan_res_t;

endpackage

// ===== rtl/enq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module enq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/enq_dist.sv =====
// Squared-distance pipeline: absolute difference, square, then sum and radius compare.
module enq_dist import enq_pkg::*; #(
  parameter int unsigned DIMS = DIMS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [DIMS*COORD_W-1:0] qrow_i,
  input  logic [DIMS*COORD_W-1:0] row_i,
  input  scan_tag_t               tag_i,
  input  logic [RADIUS_W-1:0]     radius_i,
  output scan_res_t               res_o
);

  localparam int unsigned SUM_W = SQ_W + $clog2(DIMS);
  localparam int unsigned CMP_W = (SUM_W > RADIUS_W) ? SUM_W : RADIUS_W;

  logic signed [COORD_W:0] diff  [DIMS];
  logic [COORD_W-1:0]      mag_d [DIMS];
  logic [COORD_W-1:0]      mag_q [DIMS];
  logic [SQ_W-1:0]         sq_q  [DIMS];
  scan_tag_t               tag1_q, tag2_q;
  logic [CMP_W-1:0]        sum;

  always_comb begin
    for (int d = 0; d < DIMS; d++) begin
      diff[d] = $signed({qrow_i[d*COORD_W+COORD_W-1], qrow_i[d*COORD_W +: COORD_W]})
              - $signed({row_i[d*COORD_W+COORD_W-1], row_i[d*COORD_W +: COORD_W]});
      // magnitude of a 17-bit difference always fits in 16 bits
      mag_d[d] = diff[d][COORD_W] ? COORD_W'(-diff[d]) : COORD_W'(diff[d]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int d = 0; d < DIMS; d++) begin
      mag_q[d] <= mag_d[d];
      sq_q[d]  <= SQ_W'(mag_q[d]) * SQ_W'(mag_q[d]);
    end
  end

  always_comb begin
    sum = '0;
    for (int d = 0; d < DIMS; d++) begin
      sum = sum + CMP_W'(sq_q[d]);
    end
  end

  assign res_o.valid = tag2_q.valid;
  assign res_o.hit   = (sum <= CMP_W'(radius_i));
  assign res_o.last  = tag2_q.last;
  assign res_o.idx   = tag2_q.idx;

endmodule

// ===== rtl/epsilon_neighborhood_query_unit.sv =====
// Epsilon neighborhood query unit. A load (mode 0) writes one Q8.8 coordinate
// of one stored point; busy stays high for one cycle after the load is taken.
// A query (mode 1) scans stored points 0 to point_count-1, one RAM row (a whole
// point) per cycle, and strobes result_valid_o once for every point whose
// squared distance to the query point is at or below radius_squared, in index
// order, with last_neighbor_o on the final one. point_count is clamped to
// 1..MAX_POINTS. busy stays high after a query is taken while the scan and
// the distance pipeline drain, and the final result shows in the
// first cycle with busy low. The single RAM read port sets the scan rate. The
// result strobe cannot be held off by the receiver: each result is valid for
// exactly one cycle. A query whose point is outside the scan range and a load
// outside the store are dropped with no result and no busy cycle.
// Configuration writes are always ready and must be issued while busy is low.
module epsilon_neighborhood_query_unit import enq_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
  parameter int unsigned DIMS       = DIMS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        mode_i,
  input  logic [IDX_W-1:0]            point_index_i,
  input  logic [DIM_W-1:0]            dim_index_i,
  input  logic signed [COORD_W-1:0]   coord_value_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [RADIUS_W-1:0]         cfg_data_i,
  output logic                        result_valid_o,
  output logic [IDX_W-1:0]            neighbor_index_o,
  output logic                        last_neighbor_o
);

  localparam int unsigned AW    = $clog2(MAX_POINTS);
  localparam int unsigned ROW_W = DIMS * COORD_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_WR,
    ST_Q_ROW,
    ST_Q_SCAN,
    ST_Q_DRAIN
  } state_e;

  state_e              state_q;
  logic [RADIUS_W-1:0] radius_q;
  logic [COUNT_W-1:0]  count_q;
  logic [COUNT_W-1:0]  cnt_eff;
  logic [COUNT_W-1:0]  scan_q;
  logic                scan_last;
  logic [AW-1:0]       pidx_q;
  logic [DIM_W-1:0]    dim_q;
  logic [COORD_W-1:0]  coord_q;
  logic [ROW_W-1:0]    qrow_q;
  scan_tag_t           tag_q;
  scan_res_t           res;
  logic                pend_v_q;
  logic [IDX_W-1:0]    pend_idx_q;
  logic                flush_q;
  logic                out_valid_q;
  logic                out_last_q;
  logic [IDX_W-1:0]    out_idx_q;

  logic                accept;
  logic                load_ok;
  logic                query_ok;
  logic                ram_we;
  logic [AW-1:0]       ram_raddr;
  logic [ROW_W-1:0]    ram_wdata;
  logic [ROW_W-1:0]    ram_rdata;

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    priority if (count_q == '0) begin
      cnt_eff = COUNT_W'(1);
    end else if (count_q > COUNT_W'(MAX_POINTS)) begin
      cnt_eff = COUNT_W'(MAX_POINTS);
    end else begin
      cnt_eff = count_q;
    end
  end

  assign query_ok  = COUNT_W'(point_index_i) < cnt_eff;
  assign load_ok   = (COUNT_W'(point_index_i) < COUNT_W'(MAX_POINTS))
                  && (4'(dim_index_i) < 4'(DIMS));
  assign scan_last = (scan_q == cnt_eff - COUNT_W'(1));

  // Read the addressed row while idle, the scan row otherwise.
  assign ram_raddr = (state_q == ST_IDLE) ? point_index_i[AW-1:0] : scan_q[AW-1:0];
  assign ram_we    = (state_q == ST_LOAD_WR);

  // Merge the new coordinate into the row just read.
  always_comb begin
    for (int d = 0; d < DIMS; d++) begin
      ram_wdata[d*COORD_W +: COORD_W] = (4'(dim_q) == 4'(d)) ? coord_q
                                        : ram_rdata[d*COORD_W +: COORD_W];
    end
  end

  enq_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pidx_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  enq_dist #(
    .DIMS (DIMS)
  ) u_dist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .qrow_i   (qrow_q),
    .row_i    (ram_rdata),
    .tag_i    (tag_q),
    .radius_i (radius_q),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      radius_q    <= '0;
      count_q     <= COUNT_RESET;
      scan_q      <= '0;
      pidx_q      <= '0;
      dim_q       <= '0;
      coord_q     <= '0;
      qrow_q      <= '0;
      tag_q       <= '0;
      pend_v_q    <= 1'b0;
      pend_idx_q  <= '0;
      flush_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_idx_q   <= '0;
    end else begin
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      tag_q.valid <= 1'b0;

      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_RADIUS_SQ:   radius_q <= cfg_data_i;
          REG_POINT_COUNT: count_q  <= cfg_data_i[COUNT_W-1:0];
          default: ;
        endcase
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            pidx_q  <= point_index_i[AW-1:0];
            dim_q   <= dim_index_i;
            coord_q <= coord_value_i;
            scan_q  <= '0;
            if (mode_i == MODE_QUERY) begin
              if (query_ok) begin
                state_q <= ST_Q_ROW;
              end
            end else if (load_ok) begin
              state_q <= ST_LOAD_WR;
            end
          end
        end
        ST_LOAD_WR: begin
          state_q <= ST_IDLE;
        end
        ST_Q_ROW, ST_Q_SCAN: begin
          // query row arrives while point 0 is being fetched
          if (state_q == ST_Q_ROW) begin
            qrow_q <= ram_rdata;
          end
          tag_q   <= '{valid: 1'b1, last: scan_last, idx: IDX_W'(scan_q)};
          scan_q  <= scan_q + COUNT_W'(1);
          state_q <= scan_last ? ST_Q_DRAIN : ST_Q_SCAN;
        end
        ST_Q_DRAIN: begin
          if (flush_q) begin
            state_q <= ST_IDLE;
          end
        end
      endcase

      // Hold one match back so the final one can carry the last flag.
      if (res.valid && res.hit) begin
        if (pend_v_q) begin
          out_valid_q <= 1'b1;
          out_idx_q   <= pend_idx_q;
        end
        pend_v_q   <= 1'b1;
        pend_idx_q <= res.idx;
      end
      flush_q <= res.valid && res.last;
      if (flush_q) begin
        out_valid_q <= 1'b1;
        out_last_q  <= 1'b1;
        out_idx_q   <= pend_idx_q;
        pend_v_q    <= 1'b0;
      end
    end
  end

  assign result_valid_o   = out_valid_q;
  assign neighbor_index_o = out_idx_q;
  assign last_neighbor_o  = out_last_q;

endmodule

// ===== rtl/enq_checker.sv =====
// Port-level checker for the neighborhood query unit, bound to the top level.
`include "epsilon_neighborhood_query_unit_macros.svh"

module enq_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic result_valid_o,
  input logic last_neighbor_o
);

  // A final result ends a query: no strobe right behind it.
  `ENQ_ASSERT_NEXT(a_last_then_quiet, result_valid_o && last_neighbor_o, !result_valid_o, "result strobe directly after final result")

  // Nothing is emitted in the cycle after a new item is taken.
  `ENQ_ASSERT_NEXT(a_accept_then_quiet, start && !busy, !result_valid_o, "result strobe right after an accepted item")

  // Only the final result of a query may show while the block is idle.
  `ENQ_ASSERT_SAME(a_mid_result_busy, result_valid_o && !last_neighbor_o, busy, "non-final result while idle")

  // The block only becomes busy by taking an item.
  `ENQ_ASSERT_NEXT(a_busy_needs_start, !busy && !start, !busy, "busy rose without a start")

endmodule

bind epsilon_neighborhood_query_unit enq_checker u_enq_checker (.*);
